// ===== src/v3au_pkg.sv =====
package v3au_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STAGES   = 16;

  localparam logic [2:0] OP_SQLEN = 3'd0;
  localparam logic [2:0] OP_LEN   = 3'd1;
  localparam logic [2:0] OP_NORM  = 3'd2;
  localparam logic [2:0] OP_DOT   = 3'd3;
  localparam logic [2:0] OP_CROSS = 3'd4;
  localparam logic [2:0] OP_PERP  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SMALL = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] scalar_out;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic [1:0]         status;
  } out_t;

endpackage

// ===== src/v3au_sqrt.sv =====
module v3au_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] n,
  output logic        out_valid,
  output logic [31:0] root
);
  import v3au_pkg::*;

  localparam int STEPS = 32 / SQRT_STAGES;

  logic [63:0] rem_q [SQRT_STAGES];
  logic [63:0] res_q [SQRT_STAGES];
  logic        vld_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [63:0] src_rem;
    logic [63:0] src_res;
    logic        src_vld;
    logic [63:0] rem_next;
    logic [63:0] res_next;

    if (s == 0) begin : g_first
      assign src_rem = n;
      assign src_res = 64'd0;
      assign src_vld = in_valid;
    end else begin : g_rest
      assign src_rem = rem_q[s-1];
      assign src_res = res_q[s-1];
      assign src_vld = vld_q[s-1];
    end

    always_comb begin
      logic [63:0] bitv;
      rem_next = src_rem;
      res_next = src_res;
      for (int t = 0; t < STEPS; t++) begin
        bitv = 64'd1 << (62 - 2 * (s * STEPS + t));
        if (rem_next >= res_next + bitv) begin
          rem_next = rem_next - (res_next + bitv);
          res_next = (res_next >> 1) + bitv;
        end else begin
          res_next = res_next >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= rem_next;
      res_q[s] <= res_next;
    end
  end

  assign out_valid = vld_q[SQRT_STAGES-1];
  assign root      = res_q[SQRT_STAGES-1][31:0];

endmodule

// ===== src/v3au_div.sv =====
module v3au_div #(
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [32+FRAC_BITS-1:0] num,
  input  logic [31:0]           den,
  output logic                  out_valid,
  output logic [FRAC_BITS:0]    quo
);
  import v3au_pkg::*;

  localparam int NW = 32 + FRAC_BITS;
  localparam int QW = FRAC_BITS + 1;

  logic [NW-1:0] rem_q [QW];
  logic [31:0]   den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic          vld_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NW-1:0] src_rem;
    logic [31:0]   src_den;
    logic [QW-1:0] src_quo;
    logic          src_vld;
    logic [NW-1:0] trial;
    logic [NW-1:0] rem_next;
    logic [QW-1:0] quo_next;

    if (i == 0) begin : g_first
      assign src_rem = num;
      assign src_den = den;
      assign src_quo = '0;
      assign src_vld = in_valid;
    end else begin : g_rest
      assign src_rem = rem_q[i-1];
      assign src_den = den_q[i-1];
      assign src_quo = quo_q[i-1];
      assign src_vld = vld_q[i-1];
    end

    assign trial = NW'(src_den) << (FRAC_BITS - i);

    always_comb begin
      rem_next = src_rem;
      quo_next = src_quo;
      if (src_rem >= trial) begin
        rem_next = src_rem - trial;
        quo_next[FRAC_BITS-i] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[i] <= rem_next;
      den_q[i] <= src_den;
      quo_q[i] <= quo_next;
    end
  end

  assign out_valid = vld_q[QW-1];
  assign quo       = quo_q[QW-1];

endmodule

// ===== src/vector3_arithmetic_unit.sv =====
// Throughput: one item per cycle; busy stays low and start may be high every cycle.
// Depth is set by the 16-stage square root (two bits per stage) and the divider,
// which resolves one quotient bit per stage over FRAC_BITS + 1 stages.
// Reset clears all valid bits and threshold; results cannot be stalled.
// Payload registers are not reset.
module vector3_arithmetic_unit #(
  parameter int FRAC_BITS = v3au_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  v3au_pkg::in_t   operand,
  output logic            done,
  output v3au_pkg::out_t  result,
  input  logic            threshold_we,
  input  logic [15:0]     threshold_wdata
);
  import v3au_pkg::*;

  localparam int QW  = FRAC_BITS + 1;
  localparam int LAT = 25 + FRAC_BITS;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] sc;
    logic [2:0][31:0]   rv;
    logic [1:0]         st;
    logic [2:0]         vn;
    logic [2:0][31:0]   vs;
    logic [4:0]         e;
  } meta_t;

  function automatic logic ovf66(input logic signed [65:0] x);
    return (x > 66'sh7FFFFFFF) || (x < -66'sh80000000);
  endfunction

  function automatic logic [31:0] clip66(input logic signed [65:0] x);
    if (x > 66'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (x < -66'sh80000000) return 32'h80000000;
    return x[31:0];
  endfunction

  logic [15:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'd0;
    end else if (threshold_we) begin
      threshold <= threshold_wdata;
    end
  end

  assign busy = 1'b0;

  // stage 0: capture
  in_t  in_q;
  logic vld0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_q <= operand;
  end

  // stage 1: magnitudes and perpendicular seed
  logic signed [31:0] av [3];
  logic [31:0]        m [3];
  logic [2:0]         neg;
  logic [2:0][31:0]   v_next;
  logic [2:0]         vn_next;

  assign av[0] = in_q.a_x;
  assign av[1] = in_q.a_y;
  assign av[2] = in_q.a_z;

  always_comb begin
    logic               kf;
    logic [1:0]         k;
    logic signed [33:0] osum;
    logic signed [33:0] num;
    logic [33:0]        nmag;
    logic [32:0]        u [3];
    logic [2:0]         un;
    logic               big;
    for (int j = 0; j < 3; j++) begin
      neg[j] = av[j][31];
      m[j]   = neg[j] ? 32'(-av[j]) : 32'(av[j]);
    end
    kf = 1'b0;
    k  = 2'd0;
    for (int j = 2; j >= 0; j--) begin
      if (m[j] > {16'd0, threshold}) begin
        kf = 1'b1;
        k  = 2'(j);
      end
    end
    case (k)
      2'd0:    osum = 34'(av[1]) + 34'(av[2]);
      2'd1:    osum = 34'(av[0]) + 34'(av[2]);
      default: osum = 34'(av[0]) + 34'(av[1]);
    endcase
    num  = neg[k] ? osum : -osum;
    nmag = num[33] ? 34'(-num) : 34'(num);
    big  = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (2'(j) == k) begin
        u[j]  = nmag[32:0];
        un[j] = num[33];
      end else begin
        u[j]  = {1'b0, m[k]};
        un[j] = 1'b0;
      end
      if (u[j] > 33'h7FFFFFFF) big = 1'b1;
    end
    for (int j = 0; j < 3; j++) begin
      if (big) u[j] = u[j] >> 1;
      if (!kf) begin
        u[j]  = 33'd1;
        un[j] = 1'b0;
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (in_q.op == OP_PERP) begin
        v_next[j]  = u[j][31:0];
        vn_next[j] = un[j];
      end else begin
        v_next[j]  = m[j];
        vn_next[j] = neg[j];
      end
    end
  end

  in_t              in1;
  logic [2:0][31:0] v1;
  logic [2:0]       vn1;
  logic             vld1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    in1 <= in_q;
    v1  <= v_next;
    vn1 <= vn_next;
  end

  // stage 2: products
  logic [2:0]         op2;
  logic [2:0][31:0]   v2;
  logic [2:0]         vn2;
  logic [63:0]        sq2 [3];
  logic signed [63:0] dp2 [3];
  logic signed [63:0] cp2 [3];
  logic signed [63:0] cn2 [3];
  logic               vld2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    op2 <= in1.op;
    v2  <= v1;
    vn2 <= vn1;
    for (int j = 0; j < 3; j++) begin
      sq2[j] <= 64'(v1[j]) * 64'(v1[j]);
    end
    dp2[0] <= 64'(in1.a_x) * 64'(in1.b_x);
    dp2[1] <= 64'(in1.a_y) * 64'(in1.b_y);
    dp2[2] <= 64'(in1.a_z) * 64'(in1.b_z);
    cp2[0] <= 64'(in1.a_y) * 64'(in1.b_z);
    cn2[0] <= 64'(in1.a_z) * 64'(in1.b_y);
    cp2[1] <= 64'(in1.a_z) * 64'(in1.b_x);
    cn2[1] <= 64'(in1.a_x) * 64'(in1.b_z);
    cp2[2] <= 64'(in1.a_x) * 64'(in1.b_y);
    cn2[2] <= 64'(in1.a_y) * 64'(in1.b_x);
  end

  // stage 3: sums and direct results
  meta_t       meta3_next;
  logic [63:0] s3_next;

  always_comb begin
    logic signed [65:0] dsum;
    logic signed [65:0] csum [3];
    logic [63:0]        sl;
    logic [2:0]         cov;
    s3_next = sq2[0] + sq2[1] + sq2[2];
    sl      = s3_next >> FRAC_BITS;
    dsum    = (66'(dp2[0]) + 66'(dp2[1]) + 66'(dp2[2])) >>> FRAC_BITS;
    for (int j = 0; j < 3; j++) begin
      csum[j] = (66'(cp2[j]) - 66'(cn2[j])) >>> FRAC_BITS;
      cov[j]  = ovf66(csum[j]);
    end
    meta3_next    = '0;
    meta3_next.op = op2;
    meta3_next.vn = vn2;
    meta3_next.vs = v2;
    meta3_next.st = ST_OK;
    case (op2)
      OP_SQLEN: begin
        if (sl > 64'h7FFFFFFF) begin
          meta3_next.sc = 32'h7FFFFFFF;
          meta3_next.st = ST_SAT;
        end else begin
          meta3_next.sc = sl[31:0];
        end
      end
      OP_DOT: begin
        meta3_next.sc = clip66(dsum);
        if (ovf66(dsum)) meta3_next.st = ST_SAT;
      end
      OP_CROSS: begin
        for (int j = 0; j < 3; j++) begin
          meta3_next.rv[j] = clip66(csum[j]);
        end
        if (cov != 3'b000) meta3_next.st = ST_SAT;
      end
      default: begin
      end
    endcase
  end

  meta_t       meta3;
  logic [63:0] s3;
  logic        vld3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    meta3 <= meta3_next;
    s3    <= s3_next;
  end

  // stage 4: leading zero pairs
  logic [4:0] e4_next;
  meta_t      meta4_next;

  always_comb begin
    e4_next = 5'd31;
    for (int i = 0; i < 32; i++) begin
      if (s3[2*i +: 2] != 2'b00) e4_next = 5'(31 - i);
    end
    meta4_next   = meta3;
    meta4_next.e = e4_next;
  end

  meta_t       meta4;
  logic [63:0] s4;
  logic        vld4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    meta4 <= meta4_next;
    s4    <= s3;
  end

  // stage 5: normalize
  meta_t       meta5_next;
  meta_t       meta5;
  logic [63:0] sn5;
  logic        vld5;

  always_comb begin
    meta5_next = meta4;
    for (int j = 0; j < 3; j++) begin
      meta5_next.vs[j] = meta4.vs[j] << meta4.e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else begin
      vld5 <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    meta5 <= meta5_next;
    sn5   <= s4 << {meta4.e, 1'b0};
  end

  // square root
  logic        sqrt_vld;
  logic [31:0] len;
  meta_t       meta_s [SQRT_STAGES];

  v3au_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld5),
    .n         (sn5),
    .out_valid (sqrt_vld),
    .root      (len)
  );

  always_ff @(posedge clk) begin
    meta_s[0] <= meta5;
    for (int i = 1; i < SQRT_STAGES; i++) begin
      meta_s[i] <= meta_s[i-1];
    end
  end

  // stage 6: length result and divider operands
  meta_t       meta6_next;
  meta_t       meta6;
  logic [31:0] len6;
  logic        vld6;

  always_comb begin
    logic [31:0] sq;
    sq         = len >> meta_s[SQRT_STAGES-1].e;
    meta6_next = meta_s[SQRT_STAGES-1];
    case (meta6_next.op)
      OP_LEN: begin
        if (sq > 32'h7FFFFFFF) begin
          meta6_next.sc = 32'h7FFFFFFF;
          meta6_next.st = ST_SAT;
        end else begin
          meta6_next.sc = sq;
        end
      end
      OP_NORM: begin
        if (sq <= {16'd0, threshold}) meta6_next.st = ST_SMALL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6 <= 1'b0;
    end else begin
      vld6 <= sqrt_vld;
    end
  end

  always_ff @(posedge clk) begin
    meta6 <= meta6_next;
    len6  <= len;
  end

  // division lanes
  logic [2:0]    div_vld;
  logic [QW-1:0] quo [3];
  meta_t         meta_d [QW];

  for (genvar j = 0; j < 3; j++) begin : g_div
    v3au_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld6),
      .num       ({meta6.vs[j], {FRAC_BITS{1'b0}}}),
      .den       (len6),
      .out_valid (div_vld[j]),
      .quo       (quo[j])
    );
  end

  always_ff @(posedge clk) begin
    meta_d[0] <= meta6;
    for (int i = 1; i < QW; i++) begin
      meta_d[i] <= meta_d[i-1];
    end
  end

  // output
  out_t result_next;

  always_comb begin
    meta_t              mt;
    logic signed [31:0] q [3];
    mt = meta_d[QW-1];
    for (int j = 0; j < 3; j++) begin
      q[j] = mt.vn[j] ? -signed'(32'(quo[j])) : signed'(32'(quo[j]));
    end
    result_next            = '0;
    result_next.status     = mt.st;
    case (mt.op)
      OP_SQLEN, OP_LEN, OP_DOT: begin
        result_next.scalar_out = mt.sc;
      end
      OP_CROSS: begin
        result_next.r_x = mt.rv[0];
        result_next.r_y = mt.rv[1];
        result_next.r_z = mt.rv[2];
      end
      OP_NORM, OP_PERP: begin
        if (mt.st != ST_SMALL) begin
          result_next.r_x = q[0];
          result_next.r_y = q[1];
          result_next.r_z = q[2];
        end
      end
      default: begin
        result_next.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("item lost in pipeline");

  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status != 2'd3))
    else $error("illegal status code");

  assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_SMALL) |->
      (result.r_x == 0 && result.r_y == 0 && result.r_z == 0 && result.scalar_out == 0))
    else $error("too-small result not zero");

  assert property (@(posedge clk) disable iff (rst)
    div_vld[0] |-> (div_vld[1] && div_vld[2]))
    else $error("division lanes out of step");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import v3au_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_t         operand;
  logic        done;
  out_t        result;
  logic        threshold_we;
  logic [15:0] threshold_wdata;

  out_t        expected_results[$];
  logic [15:0] threshold;
  int          errors;
  int          items_sent;
  int          results_seen;
  bit          gaps_on;

  vector3_arithmetic_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operand(operand),
    .done(done),
    .result(result),
    .threshold_we(threshold_we),
    .threshold_wdata(threshold_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sh7fffffff) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sh80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  task automatic unit_vector(input logic [63:0] mag[3], input logic sgn[3], input logic [63:0] s,
                             output logic signed [31:0] r[3]);
    int unsigned e;
    logic [63:0] len;
    logic [63:0] q;
    e = 0;
    while (s < (64'd1 << 62)) begin
      s = s << 2;
      e++;
    end
    len = int_sqrt(s);
    for (int j = 0; j < 3; j++) begin
      q = ((mag[j] << e) << FRAC_BITS_DEF) / len;
      r[j] = sgn[j] ? -q[31:0] : q[31:0];
    end
  endtask

  task automatic compute_result(input in_t x, input logic [15:0] thr, output out_t y);
    logic signed [63:0]  a[3];
    logic signed [63:0]  b[3];
    logic [63:0]         m[3];
    logic [63:0]         u[3];
    logic                neg[3];
    logic                un[3];
    logic signed [31:0]  r[3];
    logic [63:0]         s;
    logic [63:0]         v;
    logic signed [127:0] acc;
    logic signed [63:0]  num;
    logic                sat;
    logic                big;
    int                  k;
    a[0] = x.a_x; a[1] = x.a_y; a[2] = x.a_z;
    b[0] = x.b_x; b[1] = x.b_y; b[2] = x.b_z;
    y = '0;
    sat = 1'b0;
    s = 0;
    for (int j = 0; j < 3; j++) begin
      neg[j] = a[j] < 0;
      m[j] = neg[j] ? -a[j] : a[j];
      s = s + m[j] * m[j];
      r[j] = 0;
      un[j] = 1'b0;
    end
    case (x.op)
      OP_SQLEN: begin
        v = s >> FRAC_BITS_DEF;
        if (v > 64'h7fffffff) begin
          sat = 1'b1;
          v = 64'h7fffffff;
        end
        y.scalar_out = v[31:0];
      end
      OP_LEN: begin
        v = int_sqrt(s);
        if (v > 64'h7fffffff) begin
          sat = 1'b1;
          v = 64'h7fffffff;
        end
        y.scalar_out = v[31:0];
      end
      OP_NORM: begin
        if (int_sqrt(s) <= {48'd0, thr}) y.status = ST_SMALL;
        else unit_vector(m, neg, s, r);
      end
      OP_DOT: begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc = acc + a[j] * b[j];
        y.scalar_out = clip32(acc >>> FRAC_BITS_DEF, sat);
      end
      OP_CROSS: begin
        for (int j = 0; j < 3; j++) begin
          acc = a[(j + 1) % 3] * b[(j + 2) % 3];
          acc = acc - a[(j + 2) % 3] * b[(j + 1) % 3];
          r[j] = clip32(acc >>> FRAC_BITS_DEF, sat);
        end
      end
      OP_PERP: begin
        k = -1;
        for (int j = 0; j < 3; j++)
          if (k < 0 && m[j] > {48'd0, thr}) k = j;
        if (k < 0) begin
          for (int j = 0; j < 3; j++) u[j] = 1;
        end else begin
          num = 0;
          big = 1'b0;
          for (int j = 0; j < 3; j++)
            if (j != k) num = num - a[j];
          if (neg[k]) num = -num;
          for (int j = 0; j < 3; j++) begin
            if (j == k) begin
              un[j] = num < 0;
              u[j] = num < 0 ? -num : num;
            end else begin
              u[j] = m[k];
            end
            if (u[j] > 64'h7fffffff) big = 1'b1;
          end
          if (big)
            for (int j = 0; j < 3; j++) u[j] = u[j] >> 1;
        end
        s = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        unit_vector(u, un, s, r);
      end
      default: ;
    endcase
    y.r_x = r[0];
    y.r_y = r[1];
    y.r_z = r[2];
    if (sat) y.status = ST_SAT;
  endtask

  task automatic send_item(input in_t x);
    out_t y;
    bit accepted;
    while (gaps_on && $urandom_range(99) < 15) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operand <= x;
    accepted = 0;
    while (!accepted) begin
      @(negedge clk);
      accepted = !busy;
      @(posedge clk);
    end
    compute_result(x, threshold, y);
    expected_results.push_back(y);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [15:0] v);
    drain();
    threshold_we <= 1'b1;
    threshold_wdata <= v;
    @(posedge clk);
    threshold_we <= 1'b0;
    threshold = v;
  endtask

  always @(negedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %h", result);
        errors++;
      end else begin
        out_t e;
        e = expected_results.pop_front();
        if (result.scalar_out !== e.scalar_out) begin
          $error("scalar_out expected %h actual %h", e.scalar_out, result.scalar_out);
          errors++;
        end
        if (result.r_x !== e.r_x) begin
          $error("r_x expected %h actual %h", e.r_x, result.r_x);
          errors++;
        end
        if (result.r_y !== e.r_y) begin
          $error("r_y expected %h actual %h", e.r_y, result.r_y);
          errors++;
        end
        if (result.r_z !== e.r_z) begin
          $error("r_z expected %h actual %h", e.r_z, result.r_z);
          errors++;
        end
        if (result.status !== e.status) begin
          $error("status expected %h actual %h", e.status, result.status);
          errors++;
        end
      end
    end
  end

  function automatic in_t make_item(input logic [2:0] op, input int ax, input int ay,
                                    input int az, input int bx, input int by, input int bz);
    in_t x;
    x.op = op;
    x.a_x = ax; x.a_y = ay; x.a_z = az;
    x.b_x = bx; x.b_y = by; x.b_z = bz;
    return x;
  endfunction

  function automatic logic [31:0] random_component(input logic [15:0] thr);
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(9))
      0, 1, 2: return w;
      3, 4: return $urandom_range(2 * thr + 2) - (thr + 1);
      5: return 0;
      6: return w[0] ? 32'h80000000 : 32'h7fffffff;
      7: return $signed(w) >>> 12;
      8: return $signed(w) >>> $urandom_range(31);
      default: return $urandom_range(8) - 4;
    endcase
  endfunction

  task automatic test_each_operation();
    for (int op = 0; op < 8; op++) begin
      send_item(make_item(3'(op), 32'h00010000, 32'h00020000, -32'h00030000,
                          32'h00008000, -32'h00010000, 32'h00040000));
    end
  endtask

  task automatic test_extremes();
    send_item(make_item(OP_SQLEN, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0));
    send_item(make_item(OP_LEN, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0));
    send_item(make_item(OP_NORM, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0));
    send_item(make_item(OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000));
    send_item(make_item(OP_DOT, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000, 32'h80000000));
    send_item(make_item(OP_CROSS, 32'h80000000, 32'h7fffffff, 32'h80000000,
                        32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send_item(make_item(OP_PERP, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0));
    send_item(make_item(OP_PERP, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0));
  endtask

  task automatic test_special_cases();
    send_item(make_item(OP_NORM, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_NORM, 1, 0, 0, 0, 0, 0));
    send_item(make_item(OP_NORM, 0, 0, -1, 0, 0, 0));
    send_item(make_item(OP_PERP, 0, 0, 0, 0, 0, 0));
    send_item(make_item(OP_PERP, 0, 0, -1, 0, 0, 0));
    send_item(make_item(OP_PERP, 0, 32'h00010000, 32'h00010000, 0, 0, 0));
  endtask

  task automatic test_threshold_edges();
    set_threshold(16'hffff);
    send_item(make_item(OP_NORM, 32'h0000ffff, 0, 0, 0, 0, 0));
    send_item(make_item(OP_NORM, 32'h00010000, 0, 0, 0, 0, 0));
    send_item(make_item(OP_PERP, -32'h0000ffff, 32'h0000ffff, 32'h00010000, 0, 0, 0));
    send_item(make_item(OP_PERP, 32'h0000ffff, -32'h0000ffff, 32'h0000ffff, 0, 0, 0));
  endtask

  task automatic test_random(input int n, input bit gaps);
    in_t x;
    gaps_on = gaps;
    for (int i = 0; i < n; i++) begin
      x.op = ($urandom_range(19) == 0) ? 3'(6 + $urandom_range(1)) : 3'($urandom_range(5));
      x.a_x = random_component(threshold);
      x.a_y = random_component(threshold);
      x.a_z = random_component(threshold);
      x.b_x = random_component(threshold);
      x.b_y = random_component(threshold);
      x.b_z = random_component(threshold);
      send_item(x);
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    gaps_on = 1'b1;
    threshold = 0;
    rst = 1'b1;
    start = 1'b0;
    operand = '0;
    threshold_we = 1'b0;
    threshold_wdata = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_each_operation();
    test_extremes();
    test_special_cases();
    test_threshold_edges();

    set_threshold(16'h0000);
    test_random(200, 1'b0);
    test_random(150, 1'b1);
    set_threshold(16'hffff);
    test_random(150, 1'b1);
    set_threshold(16'($urandom));
    test_random(150, 1'b1);
    set_threshold(16'h0100);
    test_random(150, 1'b1);

    drain();
    $display("covered %0d items over all opcodes and several threshold settings, %0d results",
             items_sent, results_seen);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
